// File: sv/ctd_pkg.sv
// Package for the chunked transfer decoder.
// Holds phase and status codes, the size-line flag struct and the hex decode.
// No dependencies.
package ctd_pkg;

  localparam int CTD_SIZE_BITS = 32;
  localparam int CTD_LINE_MAX  = 64;
  localparam int CTD_LINE_W    = 7;

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  localparam logic [1:0] ST_RUN       = 2'd0;
  localparam logic [1:0] ST_DONE      = 2'd1;
  localparam logic [1:0] ST_MALFORMED = 2'd2;
  localparam logic [1:0] ST_TRUNC     = 2'd3;

  typedef enum logic [2:0] {
    PH_SIZE,
    PH_PAYLOAD,
    PH_TRAILER,
    PH_HALTED
  } phase_t;

  typedef struct packed {
    logic                  saw_cr;
    logic                  digit_seen;
    logic                  digits_closed;
    logic [CTD_LINE_W-1:0] line_len;
  } ctd_line_t;

  // {is_hex, value}
  function automatic logic [4:0] hex_decode(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end
    return r;
  endfunction

endpackage

// File: sv/ctd_if.sv
// Stream interfaces of the chunked transfer decoder: message bytes in,
// decoded results out. Depends on nothing.
interface ctd_msg_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       message_end;
  modport source (output valid, input ready, output in_byte, output message_end);
  modport sink   (input valid, output ready, input in_byte, input message_end);
endinterface

interface ctd_dec_if;
  logic       valid;
  logic       ready;
  logic       payload_valid;
  logic [7:0] payload_byte;
  logic [1:0] status;
  modport source (output valid, input ready, output payload_valid,
                  output payload_byte, output status);
  modport sink   (input valid, output ready, input payload_valid,
                  input payload_byte, input status);
endinterface

// File: sv/ctd_step.sv
// Per-byte decode step: next decoder state and the result for one byte.
// Depends on ctd_pkg.
module ctd_step import ctd_pkg::*; #(
  parameter int SIZE_BITS = CTD_SIZE_BITS,
  parameter int LINE_MAX  = CTD_LINE_MAX
) (
  input  phase_t                phase,
  input  logic [SIZE_BITS-1:0]  remain,
  input  logic [SIZE_BITS-1:0]  acc,
  input  ctd_line_t             line,
  input  logic [7:0]            in_byte,
  input  logic                  last,
  output phase_t                phase_next,
  output logic [SIZE_BITS-1:0]  remain_next,
  output logic [SIZE_BITS-1:0]  acc_next,
  output ctd_line_t             line_next,
  output logic                  has_result,
  output logic                  payload_valid,
  output logic [7:0]            payload_byte,
  output logic [1:0]            status
);

  localparam logic [CTD_LINE_W-1:0] LINE_LIMIT = CTD_LINE_W'(LINE_MAX);

  logic [4:0] hd;
  logic       lf_end, too_long, is_ws, take_digit, ovf, acc_zero;
  logic       ev_malformed, ev_done, halted_after;

  assign hd         = hex_decode(in_byte);
  assign lf_end     = line.saw_cr && (in_byte == CH_LF);
  assign too_long   = line.line_len >= LINE_LIMIT;
  assign is_ws      = (in_byte == CH_SPACE) || (in_byte == CH_TAB);
  assign take_digit = !line.digits_closed && !(!line.digit_seen && is_ws) && hd[4];
  assign ovf        = |acc[SIZE_BITS-1:SIZE_BITS-4];
  assign acc_zero   = (acc == '0);

  assign ev_malformed = too_long || (lf_end && !line.digit_seen) ||
                        (!lf_end && take_digit && ovf);
  assign ev_done      = !too_long && lf_end && line.digit_seen && acc_zero;
  assign halted_after = (phase == PH_HALTED) ||
                        ((phase == PH_SIZE) && (ev_malformed || ev_done));

  always_comb begin
    phase_next  = phase;
    remain_next = remain;
    acc_next    = acc;
    line_next   = line;
    unique case (phase)
      PH_SIZE: begin
        if (too_long) begin
          phase_next = PH_HALTED;
        end else begin
          line_next.line_len = line.line_len + CTD_LINE_W'(1);
          if (lf_end) begin
            if (!line.digit_seen || acc_zero) begin
              phase_next = PH_HALTED;
            end else begin
              phase_next  = PH_PAYLOAD;
              remain_next = acc;
              acc_next    = '0;
              line_next   = '0;
            end
          end else begin
            line_next.saw_cr = (in_byte == CH_CR);
            if (!line.digits_closed) begin
              if (!line.digit_seen && is_ws) begin
                // leading white space skipped
              end else if (hd[4]) begin
                if (ovf) begin
                  phase_next = PH_HALTED;
                end else begin
                  acc_next             = {acc[SIZE_BITS-5:0], hd[3:0]};
                  line_next.digit_seen = 1'b1;
                end
              end else begin
                line_next.digits_closed = 1'b1;
              end
            end
          end
        end
      end
      PH_PAYLOAD: begin
        remain_next = remain - SIZE_BITS'(1);
        if (remain == SIZE_BITS'(1)) begin
          phase_next       = PH_TRAILER;
          line_next.saw_cr = 1'b0;
        end
      end
      PH_TRAILER: begin
        if (lf_end) begin
          phase_next = PH_SIZE;
          acc_next   = '0;
          line_next  = '0;
        end else begin
          line_next.saw_cr = (in_byte == CH_CR);
        end
      end
      PH_HALTED: begin
        phase_next = PH_HALTED;
      end
      default: begin
        phase_next = PH_HALTED;
      end
    endcase
    if (last) begin
      phase_next  = PH_SIZE;
      remain_next = '0;
      acc_next    = '0;
      line_next   = '0;
    end
  end

  always_comb begin
    payload_valid = (phase == PH_PAYLOAD);
    payload_byte  = payload_valid ? in_byte : 8'd0;
    status        = ST_RUN;
    if (phase == PH_SIZE) begin
      if (ev_malformed) begin
        status = ST_MALFORMED;
      end else if (ev_done) begin
        status = ST_DONE;
      end
    end
    if (last && !halted_after) begin
      status = ST_TRUNC;
    end
    has_result = (phase != PH_HALTED) && (payload_valid || (status != ST_RUN));
  end

endmodule

// File: sv/chunked_transfer_decoder_unit.sv
// Top level of the chunked transfer decoder: input register, state, result
// register. Depends on ctd_pkg, ctd_if and ctd_step.
//
// Usage:
//   msg carries one message byte per transaction, with message_end set on the
//   last byte of a message. dec carries one result per transaction: a decoded
//   payload byte (payload_valid set) and/or a status event (done, malformed
//   size line, truncated message). Bytes that only frame the body (size lines,
//   CR LF, extensions, bytes after done) give no result transaction.
//   Throughput: one byte per clock while dec takes results; the per-byte state update is a
//   single compare and shift-add pass of ctd_step between the input register
//   and the result register.
//   Results are offered from the result register, not straight from ctd_step.
//   Reset (rst, synchronous) empties both registers and puts the decoder in
//   the size-line phase; message_end resets the decoder state after its byte.
//   When dec stalls, the held result and one buffered byte wait; msg.ready
//   drops only while both are full.
module chunked_transfer_decoder_unit import ctd_pkg::*; #(
  parameter int SIZE_BITS = CTD_SIZE_BITS,
  parameter int LINE_MAX  = CTD_LINE_MAX
) (
  input  logic      clk,
  input  logic      rst,
  ctd_msg_if.sink   msg,
  ctd_dec_if.source dec
);

  logic                 s1_valid;
  logic [7:0]           s1_byte;
  logic                 s1_last;

  phase_t               phase, phase_next;
  logic [SIZE_BITS-1:0] remain, remain_next;
  logic [SIZE_BITS-1:0] acc, acc_next;
  ctd_line_t            line, line_next;

  logic                 o_valid;
  logic                 o_pv;
  logic [7:0]           o_pb;
  logic [1:0]           o_status;

  logic                 has_result, r_pv;
  logic [7:0]           r_pb;
  logic [1:0]           r_status;
  logic                 out_free, proc;

  ctd_step #(
    .SIZE_BITS (SIZE_BITS),
    .LINE_MAX  (LINE_MAX)
  ) u_step (
    .phase         (phase),
    .remain        (remain),
    .acc           (acc),
    .line          (line),
    .in_byte       (s1_byte),
    .last          (s1_last),
    .phase_next    (phase_next),
    .remain_next   (remain_next),
    .acc_next      (acc_next),
    .line_next     (line_next),
    .has_result    (has_result),
    .payload_valid (r_pv),
    .payload_byte  (r_pb),
    .status        (r_status)
  );

  assign out_free  = !o_valid || dec.ready;
  assign proc      = s1_valid && out_free;
  assign msg.ready = !s1_valid || proc;

  assign dec.valid         = o_valid;
  assign dec.payload_valid = o_pv;
  assign dec.payload_byte  = o_pb;
  assign dec.status        = o_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (msg.ready) begin
      s1_valid <= msg.valid;
    end
    if (msg.ready && msg.valid) begin
      s1_byte <= msg.in_byte;
      s1_last <= msg.message_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_SIZE;
      remain <= '0;
      acc    <= '0;
      line   <= '0;
    end else if (proc) begin
      phase  <= phase_next;
      remain <= remain_next;
      acc    <= acc_next;
      line   <= line_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (out_free) begin
      o_valid <= proc && has_result;
    end
    if (proc && has_result) begin
      o_pv     <= r_pv;
      o_pb     <= r_pb;
      o_status <= r_status;
    end
  end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// Testbench for chunked_transfer_decoder_unit: sends chunked message bodies byte by
// byte, predicts payload bytes and status events, checks each result transaction.
// Depends on ctd_pkg, ctd_if and the decoder RTL.
module tb_top;
  import ctd_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int IDLE_PCT     = 22;
  localparam int RANDOM_BYTES = 1700;

  typedef struct packed {
    logic       pv;
    logic [7:0] pb;
    logic [1:0] st;
  } dec_result_t;

  logic clk;
  logic rst;

  ctd_msg_if msg_ch();
  ctd_dec_if dec_ch();

  chunked_transfer_decoder_unit u_top (
    .clk (clk),
    .rst (rst),
    .msg (msg_ch),
    .dec (dec_ch)
  );

  dec_result_t awaited_results[$];
  logic [7:0]  msg_buf[$];
  int          mismatches;
  int          bytes_sent;
  int          stall_cycles;
  int          hold_cycles;
  int          src_idle;
  int          snk_idle;
  dec_result_t want;
  dec_result_t got;

  // decoder shadow state
  phase_t                   ph;
  logic [CTD_SIZE_BITS-1:0] remaining;
  logic [CTD_SIZE_BITS-1:0] acc;
  logic                     cr;
  logic                     dseen;
  logic                     dclosed;
  logic [CTD_LINE_W-1:0]    llen;

  function automatic void clear_line();
    acc     = '0;
    cr      = 1'b0;
    dseen   = 1'b0;
    dclosed = 1'b0;
    llen    = '0;
  endfunction

  function automatic void rearm();
    ph        = PH_SIZE;
    remaining = '0;
    clear_line();
  endfunction

  function automatic logic [1:0] size_line_step(input logic [7:0] b);
    logic       is_hex;
    logic [3:0] nib;
    is_hex = 1'b1;
    nib    = 4'd0;
    if (b inside {[8'h30:8'h39]}) begin
      nib = b[3:0];
    end else if (b inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      nib = b[3:0] + 4'd9;
    end else begin
      is_hex = 1'b0;
    end
    if (llen >= CTD_LINE_MAX) begin
      ph = PH_HALTED;
      return ST_MALFORMED;
    end
    llen = llen + 1'b1;
    if (cr && b == CH_LF) begin
      if (!dseen) begin
        ph = PH_HALTED;
        return ST_MALFORMED;
      end
      if (acc == '0) begin
        ph = PH_HALTED;
        return ST_DONE;
      end
      remaining = acc;
      ph = PH_PAYLOAD;
      clear_line();
      return ST_RUN;
    end
    cr = (b == CH_CR);
    if (!dclosed && (dseen || !(b == CH_SPACE || b == CH_TAB))) begin
      if (is_hex) begin
        if (acc[CTD_SIZE_BITS-1 -: 4] != 4'd0) begin
          ph = PH_HALTED;
          return ST_MALFORMED;
        end
        acc   = {acc[CTD_SIZE_BITS-5:0], nib};
        dseen = 1'b1;
      end else begin
        dclosed = 1'b1;
      end
    end
    return ST_RUN;
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic last);
    logic       was_halted;
    logic       pv;
    logic [7:0] pb;
    logic [1:0] st;
    was_halted = (ph == PH_HALTED);
    pv = 1'b0;
    pb = 8'd0;
    st = ST_RUN;
    case (ph)
      PH_SIZE: st = size_line_step(b);
      PH_PAYLOAD: begin
        pv = 1'b1;
        pb = b;
        remaining = remaining - 1'b1;
        if (remaining == '0) begin
          ph = PH_TRAILER;
          cr = 1'b0;
        end
      end
      PH_TRAILER: begin
        if (cr && b == CH_LF) begin
          ph = PH_SIZE;
          clear_line();
        end else begin
          cr = (b == CH_CR);
        end
      end
      default: ph = PH_HALTED;
    endcase
    if (last) begin
      if (ph != PH_HALTED) st = ST_TRUNC;
      rearm();
    end
    if (!was_halted && (pv || st != ST_RUN)) awaited_results.push_back('{pv, pb, st});
  endfunction

  // message assembly
  function automatic void put_byte(input logic [7:0] b);
    msg_buf.push_back(b);
  endfunction

  function automatic void put_text(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endfunction

  function automatic void put_crlf();
    put_byte(CH_CR);
    put_byte(CH_LF);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + n;
    return ($urandom_range(1) ? 8'h41 : 8'h61) + n - 8'd10;
  endfunction

  function automatic void put_ws();
    put_byte($urandom_range(1) ? CH_SPACE : CH_TAB);
  endfunction

  function automatic void put_size_line(input logic [CTD_SIZE_BITS-1:0] size);
    int nd;
    repeat ($urandom_range(2)) put_ws();
    nd = 1;
    while (nd < CTD_SIZE_BITS / 4 && (size >> (4 * nd)) != '0) nd++;
    repeat ($urandom_range(2)) put_byte(8'h30);
    for (int k = nd - 1; k >= 0; k--) put_byte(hex_char(size[4*k +: 4]));
    if ($urandom_range(3) == 0) begin
      put_byte(8'h3b);
      repeat ($urandom_range(4)) put_byte(8'($urandom_range(8'h21, 8'h7e)));
    end
    put_crlf();
  endfunction

  function automatic void put_bad_line();
    case ($urandom_range(2))
      0: begin
        repeat ($urandom_range(3)) put_ws();
        if ($urandom_range(1)) begin
          put_byte(8'h3b);
          repeat ($urandom_range(3)) put_byte(8'($urandom_range(8'h21, 8'h7e)));
        end
        put_crlf();
      end
      1: begin
        put_byte(hex_char(4'($urandom_range(1, 15))));
        repeat ($urandom_range(8, 11)) put_byte(hex_char(4'($urandom)));
        put_crlf();
      end
      default: begin
        // straddles the line length limit
        put_byte(8'h31);
        put_byte(8'h3b);
        repeat ($urandom_range(56, 66)) put_byte(8'($urandom_range(8'h21, 8'h7e)));
        put_crlf();
        put_byte(8'($urandom));
        put_crlf();
      end
    endcase
  endfunction

  function automatic void build_message();
    int                       kind;
    int                       cut;
    logic [CTD_SIZE_BITS-1:0] size;
    kind = $urandom_range(99);
    if (kind < 8) begin
      repeat ($urandom_range(1, 24)) put_byte(8'($urandom));
      return;
    end
    if (kind < 22) put_bad_line();
    repeat ($urandom_range(1, 4)) begin
      size = ($urandom_range(9) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
      put_size_line(size);
      repeat (size) put_byte(8'($urandom));
      if ($urandom_range(4) == 0) repeat ($urandom_range(1, 3)) put_byte(8'($urandom));
      put_crlf();
    end
    put_size_line('0);
    if ($urandom_range(3) == 0) repeat ($urandom_range(1, 4)) put_byte(8'($urandom));
    if (kind >= 22 && kind < 40) begin
      cut = $urandom_range(1, msg_buf.size());
      while (msg_buf.size() > cut) void'(msg_buf.pop_back());
    end
  endfunction

  // transaction driving
  task automatic send_byte(input logic [7:0] b, input logic last);
    if ($urandom_range(99) < src_idle) begin
      msg_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle);
    end
    msg_ch.valid       <= 1'b1;
    msg_ch.in_byte     <= b;
    msg_ch.message_end <= last;
    do @(posedge clk); while (!msg_ch.ready);
    decode_byte(b, last);
    bytes_sent++;
  endtask

  task automatic flush_message();
    int n;
    n = msg_buf.size();
    for (int i = 0; i < n; i++) send_byte(msg_buf[i], i == n - 1);
    msg_buf.delete();
  endtask

  // tests
  task automatic test_well_formed_chunks();
    put_text(" \t3;ext=1");
    put_crlf();
    put_byte(8'h00);
    put_byte(8'hff);
    put_byte(8'h80);
    put_crlf();
    put_text("0");
    put_crlf();
    flush_message();
  endtask

  task automatic test_size_line_errors();
    put_crlf();
    put_text("x");
    flush_message();
    put_text(";a");
    put_crlf();
    flush_message();
    put_text("fffffffff");
    flush_message();
    put_text("FFFFFFFF");
    put_crlf();
    put_byte(8'h5a);
    flush_message();
    put_text("1");
    flush_message();
  endtask

  task automatic test_long_size_line();
    repeat (CTD_LINE_MAX) put_byte(CH_TAB);
    put_text("1");
    flush_message();
  endtask

  task automatic test_bytes_after_done();
    put_text("0");
    put_crlf();
    put_text("zz");
    flush_message();
  endtask

  task automatic test_output_stall();
    put_text("28");
    put_crlf();
    repeat (40) put_byte(8'($urandom));
    put_crlf();
    put_text("0");
    put_crlf();
    src_idle    = 0;
    snk_idle    = 0;
    hold_cycles = 80;
    flush_message();
    src_idle = IDLE_PCT;
    snk_idle = IDLE_PCT;
  endtask

  task automatic test_random_messages();
    int first;
    first = bytes_sent;
    while (bytes_sent - first < RANDOM_BYTES) begin
      if (bytes_sent - first >= 700 && bytes_sent - first < 1000) begin
        src_idle = 0;
        snk_idle = 0;
      end else begin
        src_idle = IDLE_PCT;
        snk_idle = IDLE_PCT;
      end
      build_message();
      flush_message();
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    dec_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        dec_ch.ready <= 1'b0;
      end else if (hold_cycles > 0) begin
        dec_ch.ready <= 1'b0;
        hold_cycles--;
      end else begin
        dec_ch.ready <= ($urandom_range(99) >= snk_idle);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && dec_ch.valid && dec_ch.ready) begin
      got = '{dec_ch.payload_valid, dec_ch.payload_byte, dec_ch.status};
      if (awaited_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("tb_top: unexpected result pv=%0b byte=%02h status=%0d",
                   got.pv, got.pb, got.st);
      end else begin
        want = awaited_results.pop_front();
        if (got.pv != want.pv || got.pb != want.pb || got.st != want.st) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"tb_top: mismatch exp pv=%0b byte=%02h status=%0d, ",
                      "got pv=%0b byte=%02h status=%0d"},
                     want.pv, want.pb, want.st, got.pv, got.pb, got.st);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (msg_ch.valid && msg_ch.ready) || (dec_ch.valid && dec_ch.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin
    mismatches   = 0;
    bytes_sent   = 0;
    stall_cycles = 0;
    hold_cycles  = 0;
    src_idle     = IDLE_PCT;
    snk_idle     = IDLE_PCT;
    rearm();
    rst                <= 1'b1;
    msg_ch.valid       <= 1'b0;
    msg_ch.in_byte     <= 8'd0;
    msg_ch.message_end <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_well_formed_chunks();
    test_size_line_errors();
    test_long_size_line();
    test_bytes_after_done();
    test_output_stall();
    test_random_messages();

    msg_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    mismatches += awaited_results.size();
    if (mismatches == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

endmodule

// File: chunked_transfer_decoder_unit.f
sv/ctd_pkg.sv
sv/ctd_if.sv
sv/ctd_step.sv
sv/chunked_transfer_decoder_unit.sv
bench/tb_top.sv
